// File: rtl/qpp_pkg.sv
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared types, codes and the modular shift-add step of the QPP interleaver.
// ----------------------------------------------------------------------------
package qpp_pkg;

  localparam int LEN_W       = 13;
  localparam int LIN_W       = 9;
  localparam int QUAD_W      = 10;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int MAX_BLOCK_DEF = 6144;

  localparam logic [LEN_W-1:0] BLOCK_LEN_RST = 13'd40;
  localparam logic [LIN_W-1:0] COEF_LIN_RST  = 9'd3;
  localparam logic [QUAD_W-1:0] COEF_QUAD_RST = 10'd10;

  typedef enum logic {
    KIND_FWD = 1'b0,
    KIND_REV = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INDEX  = 2'd1,
    ST_LENGTH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_BLOCK_LEN = 2'd0,
    REG_COEF_LIN  = 2'd1,
    REG_COEF_QUAD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  position;
  } qpp_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]  mapped_position;
    status_t           status;
  } qpp_out_t;

  // side-band that rides along the multiplier pipelines
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  pos;
    status_t           status;
  } qpp_tag_t;

  // One MSB-first step of interleaved modular multiply-add:
  // acc' = (2*acc + bbit*a + dbit) mod k, valid for acc < k, a < k.
  // Sum stays below 3k, so two conditional subtracts suffice.
  function automatic logic [LEN_W-1:0] mm_step(
    input logic [LEN_W-1:0] acc,
    input logic [LEN_W-1:0] a,
    input logic             bbit,
    input logic             dbit,
    input logic [LEN_W-1:0] k
  );
    logic [LEN_W+1:0] t;
    logic [LEN_W+1:0] kx;
    kx = {2'b00, k};
    t  = {1'b0, acc, 1'b0}
       + (bbit ? {2'b00, a} : {(LEN_W+2){1'b0}})
       + {{(LEN_W+1){1'b0}}, dbit};
    if (t >= kx) begin
      t = t - kx;
    end
    if (t >= kx) begin
      t = t - kx;
    end
    return t[LEN_W-1:0];
  endfunction

endpackage

// File: rtl/qpp_ram.sv
// ----------------------------------------------------------------------------
// qpp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qpp_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 6144,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/qpp_mulmod.sv
// ----------------------------------------------------------------------------
// qpp_mulmod
// Pipelined modular multiply-add (a*b + d) mod k, two multiplier bits per stage.
// ----------------------------------------------------------------------------
module qpp_mulmod #(
  parameter int BW = 10,   // multiplier / addend width
  parameter int TW = 16    // side-band width
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [qpp_pkg::LEN_W-1:0] in_a,   // multiplicand, < k
  input  logic [BW-1:0]            in_b,
  input  logic [BW-1:0]            in_d,
  input  logic [qpp_pkg::LEN_W-1:0] in_k,   // static while items are in flight
  input  logic [TW-1:0]            in_tag,
  output logic                     out_valid,
  output logic [qpp_pkg::LEN_W-1:0] out_r,
  output logic [TW-1:0]            out_tag
);

  localparam int NS = (BW + 1) / 2;
  localparam int PW = 2 * NS;   // multiplier padded with leading zeros

  logic [NS-1:0]              vld_r;
  logic [qpp_pkg::LEN_W-1:0]  acc_r [NS];
  logic [qpp_pkg::LEN_W-1:0]  a_r   [NS];
  logic [PW-1:0]              b_r   [NS];
  logic [PW-1:0]              d_r   [NS];
  logic [TW-1:0]              tag_r [NS];

  logic [NS-1:0]              src_vld;
  logic [qpp_pkg::LEN_W-1:0]  src_acc [NS];
  logic [qpp_pkg::LEN_W-1:0]  src_a   [NS];
  logic [PW-1:0]              src_b   [NS];
  logic [PW-1:0]              src_d   [NS];
  logic [TW-1:0]              src_tag [NS];

  logic [qpp_pkg::LEN_W-1:0]  acc_mid [NS];
  logic [qpp_pkg::LEN_W-1:0]  acc_nxt [NS];

  for (genvar s = 0; s < NS; s++) begin : g_src
    if (s == 0) begin : g_first
      assign src_vld[s] = in_valid;
      assign src_acc[s] = '0;
      assign src_a[s]   = in_a;
      assign src_b[s]   = PW'(in_b);
      assign src_d[s]   = PW'(in_d);
      assign src_tag[s] = in_tag;
    end else begin : g_next
      assign src_vld[s] = vld_r[s-1];
      assign src_acc[s] = acc_r[s-1];
      assign src_a[s]   = a_r[s-1];
      assign src_b[s]   = b_r[s-1];
      assign src_d[s]   = d_r[s-1];
      assign src_tag[s] = tag_r[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      acc_mid[s] = qpp_pkg::mm_step(src_acc[s], src_a[s], src_b[s][PW-1-2*s],
                                    src_d[s][PW-1-2*s], in_k);
      acc_nxt[s] = qpp_pkg::mm_step(acc_mid[s], src_a[s], src_b[s][PW-2-2*s],
                                    src_d[s][PW-2-2*s], in_k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= src_vld;
    end
    for (int s = 0; s < NS; s++) begin
      acc_r[s] <= acc_nxt[s];
      a_r[s]   <= src_a[s];
      b_r[s]   <= src_b[s];
      d_r[s]   <= src_d[s];
      tag_r[s] <= src_tag[s];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_r     = acc_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// File: rtl/qpp_interleaver_address_gen.sv
// ----------------------------------------------------------------------------
// qpp_interleaver_address_gen
// QPP turbo interleaver: pi(i) = (f1*i + f2*i*i) mod K, with inverse table.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Transaction
//  ---------+-----------------------------------------+------------------------------
//  request  | start, busy, in_data (kind, position)   | start && !busy at clk edge
//  result   | out_valid, out_data (mapped, status)    | one-cycle strobe, no backpressure
//  config   | psel penable pwrite paddr pwdata prdata | APB write, pready tied high
//
//  Throughput: one request per cycle, fully pipelined; busy is never raised.
//  Pipeline: input stage, 5 stages of the f2*i + f1 multiplier, 7 stages of
//    the (.)*i multiplier, table stage; out_valid follows the table stage.
//  The two bit-serial modular multipliers (2 bits per stage) set the depth.
//  Reset clears control and the registers; the inverse table is not cleared
//    and an entry reads undefined until a forward request has written it.
//  The result side cannot stall, so the pipeline never holds.
//
//  pi(i) is evaluated Horner-style as ((f2*i + f1) mod K) * i mod K; every
//  intermediate stays below K, so no wide product or divider is needed.
//  Table write (forward) and read (reverse) happen in the same stage, which
//  keeps read-after-write order between back-to-back requests.
// ----------------------------------------------------------------------------
module qpp_interleaver_address_gen #(
  parameter int MAX_BLOCK = qpp_pkg::MAX_BLOCK_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request
  input  logic                         start,
  output logic                         busy,
  input  qpp_pkg::qpp_in_t             in_data,
  // result
  output logic                         out_valid,
  output qpp_pkg::qpp_out_t            out_data,
  // config
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qpp_pkg::CFG_AW-1:0]   paddr,
  input  logic [qpp_pkg::CFG_DW-1:0]   pwdata,
  output logic [qpp_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int LEN_W  = qpp_pkg::LEN_W;
  localparam int AW     = $clog2(MAX_BLOCK);
  localparam int TW     = $bits(qpp_pkg::qpp_tag_t);
  localparam int LAT    = 2 + (qpp_pkg::QUAD_W + 1) / 2 + (LEN_W + 1) / 2;
  localparam logic [LEN_W:0] MAX_LEN = (LEN_W+1)'(MAX_BLOCK);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]            block_len_r;
  logic [qpp_pkg::LIN_W-1:0]   coef_lin_r;
  logic [qpp_pkg::QUAD_W-1:0]  coef_quad_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= qpp_pkg::BLOCK_LEN_RST;
      coef_lin_r  <= qpp_pkg::COEF_LIN_RST;
      coef_quad_r <= qpp_pkg::COEF_QUAD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        qpp_pkg::REG_BLOCK_LEN: block_len_r <= pwdata[LEN_W-1:0];
        qpp_pkg::REG_COEF_LIN:  coef_lin_r  <= pwdata[qpp_pkg::LIN_W-1:0];
        qpp_pkg::REG_COEF_QUAD: coef_quad_r <= pwdata[qpp_pkg::QUAD_W-1:0];
        default: ;  // unmapped offset, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qpp_pkg::REG_BLOCK_LEN: prdata = qpp_pkg::CFG_DW'(block_len_r);
      qpp_pkg::REG_COEF_LIN:  prdata = qpp_pkg::CFG_DW'(coef_lin_r);
      qpp_pkg::REG_COEF_QUAD: prdata = qpp_pkg::CFG_DW'(coef_quad_r);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input stage: range checks. Length check wins over index check.
  // --------------------------------------------------------------------------
  logic                 in_acc;
  qpp_pkg::status_t     in_status;
  logic                 s0_valid_r;
  qpp_pkg::qpp_tag_t    s0_tag_r;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  always_comb begin
    if ({1'b0, block_len_r} > MAX_LEN) begin
      in_status = qpp_pkg::ST_LENGTH;
    end else if (in_data.position >= block_len_r) begin
      in_status = qpp_pkg::ST_INDEX;
    end else begin
      in_status = qpp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= in_acc;
    end
    s0_tag_r.kind   <= in_data.kind;
    s0_tag_r.pos    <= in_data.position;
    s0_tag_r.status <= in_status;
  end

  // --------------------------------------------------------------------------
  // u = (f2*i + f1) mod K
  // --------------------------------------------------------------------------
  logic                 u_valid;
  logic [LEN_W-1:0]     u_val;
  logic [TW-1:0]        u_tag;

  qpp_mulmod #(
    .BW (qpp_pkg::QUAD_W),
    .TW (TW)
  ) u_mm_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_a      (s0_tag_r.pos),
    .in_b      (coef_quad_r),
    .in_d      (qpp_pkg::QUAD_W'(coef_lin_r)),
    .in_k      (block_len_r),
    .in_tag    (s0_tag_r),
    .out_valid (u_valid),
    .out_r     (u_val),
    .out_tag   (u_tag)
  );

  qpp_pkg::qpp_tag_t    u_tag_s;
  assign u_tag_s = u_tag;

  // --------------------------------------------------------------------------
  // pi = (u * i) mod K
  // --------------------------------------------------------------------------
  logic                 m_valid;
  logic [LEN_W-1:0]     m_pi;
  logic [TW-1:0]        m_tag;
  qpp_pkg::qpp_tag_t    m_tag_s;

  qpp_mulmod #(
    .BW (LEN_W),
    .TW (TW)
  ) u_mm_lin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (u_valid),
    .in_a      (u_val),
    .in_b      (u_tag_s.pos),
    .in_d      ({LEN_W{1'b0}}),
    .in_k      (block_len_r),
    .in_tag    (u_tag),
    .out_valid (m_valid),
    .out_r     (m_pi),
    .out_tag   (m_tag)
  );

  assign m_tag_s = m_tag;

  // --------------------------------------------------------------------------
  // Inverse table stage
  // --------------------------------------------------------------------------
  logic                 tbl_we;
  logic [LEN_W-1:0]     tbl_rdata;

  assign tbl_we = m_valid && (m_tag_s.kind == qpp_pkg::KIND_FWD)
               && (m_tag_s.status == qpp_pkg::ST_OK);

  qpp_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_BLOCK),
    .AW    (AW)
  ) u_inv_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (m_pi[AW-1:0]),
    .wdata (m_tag_s.pos),
    .raddr (m_tag_s.pos[AW-1:0]),
    .rdata (tbl_rdata)
  );

  logic                 e_valid_r;
  qpp_pkg::kind_t       e_kind_r;
  qpp_pkg::status_t     e_status_r;
  logic [LEN_W-1:0]     e_pi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= m_valid;
    end
    e_kind_r   <= m_tag_s.kind;
    e_status_r <= m_tag_s.status;
    e_pi_r     <= m_pi;
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  assign out_valid       = e_valid_r;
  assign out_data.status = e_status_r;

  always_comb begin
    if (e_status_r != qpp_pkg::ST_OK) begin
      out_data.mapped_position = '0;
    end else if (e_kind_r == qpp_pkg::KIND_REV) begin
      out_data.mapped_position = tbl_rdata;
    end else begin
      out_data.mapped_position = e_pi_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("accepted request did not produce a result after LAT cycles");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != qpp_pkg::ST_OK) |-> out_data.mapped_position == '0)
    else $error("error result carries a nonzero position");

  a_fwd_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (e_kind_r == qpp_pkg::KIND_FWD) && (e_status_r == qpp_pkg::ST_OK)
      |-> out_data.mapped_position < block_len_r)
    else $error("forward address not reduced below block length");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result without a matching request");

endmodule

// File: verif/qpp_interleaver_address_gen_tb.sv
// ----------------------------------------------------------------------------
// qpp_interleaver_address_gen_tb
// Self-checking bench for the QPP turbo interleaver address generator.
// Forward and reverse requests go in on the start/busy port. Every result is
// checked against an in-bench model of the permutation and the inverse table.
// The APB port steps the block through many lengths and coefficient sets:
// legal and illegal lengths, and coefficient extremes.
// ----------------------------------------------------------------------------
module qpp_interleaver_address_gen_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  // pipeline is 14 deep; leave margin before touching the registers or ending
  localparam int SETTLE_CYCLES = 20;
  localparam int LEN_W         = qpp_pkg::LEN_W;
  localparam int LIN_W         = qpp_pkg::LIN_W;
  localparam int QUAD_W        = qpp_pkg::QUAD_W;
  localparam int CFG_AW        = qpp_pkg::CFG_AW;
  localparam int CFG_DW        = qpp_pkg::CFG_DW;
  localparam int MAX_BLK       = qpp_pkg::MAX_BLOCK_DEF;
  localparam int POS_MAX       = (1 << LEN_W) - 1;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  qpp_pkg::qpp_in_t  in_data = '0;
  logic              out_valid;
  qpp_pkg::qpp_out_t out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  qpp_interleaver_address_gen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies, inverse table, result queue
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  shadow_len = qpp_pkg::BLOCK_LEN_RST;
  logic [LIN_W-1:0]  shadow_f1  = qpp_pkg::COEF_LIN_RST;
  logic [QUAD_W-1:0] shadow_f2  = qpp_pkg::COEF_QUAD_RST;

  // The RTL table powers up undefined. inv_written tracks which entries a
  // forward transaction has filled; reverse lookups only ever target those.
  logic [LEN_W-1:0]  inv_table   [MAX_BLK];
  bit                inv_written [MAX_BLK];

  qpp_pkg::qpp_out_t expected_results [$];

  int err_count     = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int fwd_count     = 0;
  int rev_count     = 0;
  int reject_count  = 0;
  int cfg_count     = 0;

  // pi(i) = (f1*i + f2*i*i) mod K; a forward hit also records i at pi(i).
  // Length check comes first, then the range check, for both kinds.
  function automatic qpp_pkg::qpp_out_t qpp_predict(qpp_pkg::qpp_in_t req);
    qpp_pkg::qpp_out_t res;
    longint unsigned   idx;
    longint unsigned   poly;
    res.mapped_position = '0;
    res.status          = qpp_pkg::ST_OK;
    if (shadow_len > MAX_BLK) begin
      res.status = qpp_pkg::ST_LENGTH;
    end else if (req.position >= shadow_len) begin
      res.status = qpp_pkg::ST_INDEX;
    end else if (req.kind == qpp_pkg::KIND_FWD) begin
      idx  = req.position;
      poly = shadow_f1 * idx + shadow_f2 * idx * idx;
      res.mapped_position = LEN_W'(poly % shadow_len);
      inv_table[res.mapped_position]   = req.position;
      inv_written[res.mapped_position] = 1'b1;
    end else begin
      res.mapped_position = inv_table[req.position];
    end
    return res;
  endfunction

  // Random filled entry below the current length, or -1 if there is none.
  function automatic int pick_filled_entry();
    int base;
    int addr;
    if (shadow_len == 0 || shadow_len > MAX_BLK) begin
      return -1;
    end
    base = $urandom_range(shadow_len - 1);
    for (int j = 0; j < shadow_len; j++) begin
      addr = (base + j) % shadow_len;
      if (inv_written[addr]) begin
        return addr;
      end
    end
    return -1;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Raise start with the transaction and hold it until an edge with busy low.
  // Returns at the accepting edge; the caller drives start for the next cycle.
  task automatic send_request(input qpp_pkg::kind_t k, input int pos,
                              output qpp_pkg::qpp_out_t expd);
    qpp_pkg::qpp_in_t req;
    req.kind     = k;
    req.position = LEN_W'(pos);
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expd = qpp_predict(req);
    expected_results.push_back(expd);
    sent_count++;
    if (expd.status != qpp_pkg::ST_OK) begin
      reject_count++;
    end else if (k == qpp_pkg::KIND_FWD) begin
      fwd_count++;
    end else begin
      rev_count++;
    end
  endtask

  // Random gap ahead of a transaction; garbage on in_data while start is low.
  task automatic idle_gap(input int pct);
    qpp_pkg::qpp_in_t junk;
    while ($urandom_range(99) < pct) begin
      junk.kind     = qpp_pkg::kind_t'($urandom_range(1));
      junk.position = LEN_W'($urandom_range(POS_MAX));
      in_data <= junk;
      start   <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start and wait for every outstanding result plus pipeline margin.
  task automatic quiesce();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB side: setup + access, then the task waits with psel low so psel never gets two NBAs
  // in the same step when calls are chained
  // --------------------------------------------------------------------------
  task automatic cfg_read(input qpp_pkg::reg_idx_t idx, output logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(input qpp_pkg::reg_idx_t idx, input logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    cfg_read(idx, got);
    if (got !== want) begin
      err_count++;
      $display("%0t: readback of %s: expected %0d, actual %0d",
               $time, idx.name(), want, got);
    end
  endtask

  task automatic cfg_write(input qpp_pkg::reg_idx_t idx, input logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // register took the value at this edge
    case (idx)
      qpp_pkg::REG_BLOCK_LEN: shadow_len = val[LEN_W-1:0];
      qpp_pkg::REG_COEF_LIN:  shadow_f1  = val[LIN_W-1:0];
      qpp_pkg::REG_COEF_QUAD: shadow_f2  = val[QUAD_W-1:0];
      default: ;
    endcase
    cfg_count++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_check(idx, val);
  endtask

  // Registers move only with the pipeline empty.
  task automatic apply_config(input int k, input int f1, input int f2);
    quiesce();
    cfg_write(qpp_pkg::REG_BLOCK_LEN, k);
    cfg_write(qpp_pkg::REG_COEF_LIN, f1);
    cfg_write(qpp_pkg::REG_COEF_QUAD, f2);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: results cannot be held off, so each strobe is taken
  // at the edge that ends its cycle and matched against the oldest entry
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    qpp_pkg::qpp_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing outstanding: expected none, actual %0d/%0d",
                 $time, out_data.mapped_position, out_data.status);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (out_data.mapped_position !== want.mapped_position) begin
          err_count++;
          $display("%0t: mapped_position: expected %0d, actual %0d",
                   $time, want.mapped_position, out_data.mapped_position);
        end
        if (out_data.status !== want.status) begin
          err_count++;
          $display("%0t: status: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values of the registers, then boundary requests at K=40, f1=3, f2=10.
  task automatic test_reset_state();
    qpp_pkg::qpp_out_t r_last;
    qpp_pkg::qpp_out_t r_zero;
    qpp_pkg::qpp_out_t r;
    cfg_check(qpp_pkg::REG_BLOCK_LEN, qpp_pkg::BLOCK_LEN_RST);
    cfg_check(qpp_pkg::REG_COEF_LIN, qpp_pkg::COEF_LIN_RST);
    cfg_check(qpp_pkg::REG_COEF_QUAD, qpp_pkg::COEF_QUAD_RST);
    send_request(qpp_pkg::KIND_FWD, 0, r_zero);
    send_request(qpp_pkg::KIND_FWD, 39, r_last);
    send_request(qpp_pkg::KIND_FWD, 1, r);
    // inverse lookups of what was just written
    send_request(qpp_pkg::KIND_REV, r_last.mapped_position, r);
    send_request(qpp_pkg::KIND_REV, r_zero.mapped_position, r);
    // index out of range: exactly K, then all position bits set
    send_request(qpp_pkg::KIND_FWD, 40, r);
    send_request(qpp_pkg::KIND_REV, 40, r);
    send_request(qpp_pkg::KIND_FWD, POS_MAX, r);
    send_request(qpp_pkg::KIND_REV, POS_MAX, r);
  endtask

  // Length above the built maximum wins over everything; K=0 rejects all.
  task automatic test_length_errors();
    qpp_pkg::qpp_out_t r;
    apply_config(MAX_BLK + 1, qpp_pkg::COEF_LIN_RST, qpp_pkg::COEF_QUAD_RST);
    send_request(qpp_pkg::KIND_FWD, 0, r);
    send_request(qpp_pkg::KIND_REV, 5, r);
    apply_config(POS_MAX, qpp_pkg::COEF_LIN_RST, qpp_pkg::COEF_QUAD_RST);
    send_request(qpp_pkg::KIND_FWD, POS_MAX, r);
    send_request(qpp_pkg::KIND_REV, 0, r);
    apply_config(0, qpp_pkg::COEF_LIN_RST, qpp_pkg::COEF_QUAD_RST);
    send_request(qpp_pkg::KIND_FWD, 0, r);
    send_request(qpp_pkg::KIND_REV, 0, r);
  endtask

  // Largest K with the widest coefficients, then zero coefficients, which
  // fold every index onto entry 0 and overwrite it.
  task automatic test_coef_extremes();
    qpp_pkg::qpp_out_t r;
    qpp_pkg::qpp_out_t r_top;
    apply_config(MAX_BLK, (1 << LIN_W) - 1, (1 << QUAD_W) - 1);
    send_request(qpp_pkg::KIND_FWD, MAX_BLK - 1, r_top);
    send_request(qpp_pkg::KIND_FWD, 4096, r);
    send_request(qpp_pkg::KIND_REV, r_top.mapped_position, r);
    apply_config(MAX_BLK, 0, 0);
    send_request(qpp_pkg::KIND_FWD, 100, r);
    send_request(qpp_pkg::KIND_REV, 0, r);
  endtask

  // Mostly well-formed traffic: forward hits, then inverse lookups of filled
  // entries; the rest is out-of-range and fully random positions.
  task automatic random_mix(input int count, input int idle_pct);
    qpp_pkg::qpp_out_t r;
    qpp_pkg::kind_t    k;
    int                pos;
    int                roll;
    for (int n = 0; n < count; n++) begin
      idle_gap(idle_pct);
      roll = $urandom_range(99);
      k    = qpp_pkg::kind_t'($urandom_range(1));
      pos  = $urandom_range(POS_MAX);
      if (shadow_len != 0 && shadow_len <= MAX_BLK) begin
        if (roll < 45) begin
          k   = qpp_pkg::KIND_FWD;
          pos = $urandom_range(shadow_len - 1);
        end else if (roll < 80) begin
          pos = pick_filled_entry();
          k   = (pos < 0) ? qpp_pkg::KIND_FWD : qpp_pkg::KIND_REV;
          if (pos < 0) pos = $urandom_range(shadow_len - 1);
        end else if (roll < 90) begin
          pos = $urandom_range(POS_MAX, shadow_len);
        end else if (k == qpp_pkg::KIND_REV && pos < shadow_len && !inv_written[pos]) begin
          // never read an entry that was not filled
          k = qpp_pkg::KIND_FWD;
        end
      end
      send_request(k, pos, r);
    end
  endtask

  // Phases sweep lengths and coefficients under different request gaps.
  task automatic test_random_traffic();
    apply_config(40, 3, 10);
    random_mix(100, 0);
    apply_config(MAX_BLK, 263, 480);
    random_mix(100, 65);
    apply_config($urandom_range(MAX_BLK, 40), $urandom_range((1 << LIN_W) - 1, 1),
                 $urandom_range((1 << QUAD_W) - 1));
    random_mix(90, 8);
    apply_config(MAX_BLK, (1 << LIN_W) - 1, (1 << QUAD_W) - 1);
    random_mix(100, 0);
    // short blocks, arbitrary coefficients, f1 of zero allowed
    apply_config($urandom_range(200, 40), $urandom_range((1 << LIN_W) - 1),
                 $urandom_range((1 << QUAD_W) - 1));
    random_mix(80, 65);
    apply_config($urandom_range(POS_MAX, MAX_BLK + 1), $urandom_range((1 << LIN_W) - 1),
                 $urandom_range((1 << QUAD_W) - 1));
    random_mix(40, 8);
    // degenerate one-entry block
    apply_config(1, $urandom_range((1 << LIN_W) - 1), $urandom_range((1 << QUAD_W) - 1));
    random_mix(40, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_length_errors();
    test_coef_extremes();
    test_random_traffic();
    quiesce();
    $display("covered %0d requests: %0d forward, %0d reverse, %0d rejected; %0d reg writes",
             sent_count, fwd_count, rev_count, reject_count, cfg_count);
    $display("%0d results compared, %0d mismatches", checked_count, err_count);
    if (err_count == 0) begin
      $display("[qpp_interleaver_address_gen] OK");
    end else begin
      $display("[qpp_interleaver_address_gen] ERROR");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports an error.
  initial begin
    #2_000_000;
    $display("[qpp_interleaver_address_gen] ERROR");
    $finish;
  end

endmodule
